FILE: sv/indexed_min_heap_defines.svh
// Assertion macros for the indexed min-heap.
// Used by the top level only; no dependencies.
`ifndef INDEXED_MIN_HEAP_DEFINES_SVH
`define INDEXED_MIN_HEAP_DEFINES_SVH
`ifndef SYNTHESIS
`define IMH_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define IMH_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("%m failed");
`else
`define IMH_ASSERT_IMPL(label, clk, rst_n, prop)
`define IMH_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: sv/imh_pkg.sv
// Shared types and constants for the indexed min-heap.
// No dependencies.
package imh_pkg;
  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned KEY_BITS_DEF = 32;
  localparam int unsigned ID_BITS = 8;
  localparam int unsigned ID_SPACE = 256;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_ADJUST = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_PRESENT = 2'd3;

  // Command handed from the front to the back.
  typedef struct packed {
    logic [1:0]        req;
    logic [ID_BITS-1:0] id;
    logic [31:0]       key;
  } cmd_t;
endpackage

FILE: sv/indexed_min_heap.sv
// Indexed min-heap, one request at a time; a level sifted up runs UPRD, UPCMP, a level down DNRD, DNRD2, DNCMP.
// Every request ends in a result strobe, also a rejected or no-op one; an insert sifts up,
// an adjust or remove reads the entry's slot first and then sifts.
// The back takes a new request only once idle after the last result; two requests queue ahead of it.
// Reset (rst_n low, synchronous) empties the heap; result strobe cannot stall.
module indexed_min_heap #(
  parameter int unsigned CAPACITY = imh_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = imh_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_item_id,
  input  logic [31:0] in_item_key,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic        out_top_valid,
  output logic [7:0]  out_top_id,
  output logic [31:0] out_top_key,
  output logic [8:0]  out_entry_count
);
  import imh_pkg::*;
  `include "indexed_min_heap_defines.svh"

  cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;
  assign in_cmd = '{req: in_req_type, id: in_item_id, key: in_item_key};

  imh_front u_front (.clk, .rst_n, .start, .busy, .in_cmd, .q_valid, .q_cmd, .q_pop);

  imh_back #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop, .out_valid, .out_status,
    .out_top_valid, .out_top_id, .out_top_key, .out_entry_count);

  `IMH_ASSERT_NEVER(a_pop_empty, clk, rst_n, q_pop && !q_valid)
  `IMH_ASSERT_NEVER(a_cnt_range, clk, rst_n, out_valid && out_entry_count > 9'(CAPACITY))
  `IMH_ASSERT_IMPL(a_top_empty, clk, rst_n,
    (out_valid && !out_top_valid) |-> (out_entry_count == 9'd0))
endmodule

FILE: sv/imh_front.sv
// Front end of the indexed min-heap: accepts requests into a short queue.
// Depends on imh_pkg.
module imh_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  imh_pkg::cmd_t in_cmd,
  output logic          q_valid,
  output imh_pkg::cmd_t q_cmd,
  input  logic          q_pop
);
  import imh_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= in_cmd;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule

FILE: sv/imh_back.sv
// Back end of the indexed min-heap: heap memories and the sift sequencer.
// Depends on imh_pkg.
module imh_back #(
  parameter int unsigned CAPACITY = imh_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = imh_pkg::KEY_BITS_DEF,
  localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  imh_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  output logic [1:0]    out_status,
  output logic          out_top_valid,
  output logic [7:0]    out_top_id,
  output logic [31:0]   out_top_key,
  output logic [8:0]    out_entry_count
);
  import imh_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_RPOS = 4'd1, S_RLAST = 4'd2,
    S_SEL = 4'd3, S_UPRD = 4'd4, S_UPCMP = 4'd5, S_DNRD = 4'd6,
    S_DNCMP = 4'd7, S_DONE = 4'd8, S_TOP = 4'd9, S_WAIT = 4'd10,
    S_DNRD2 = 4'd11, S_OUT = 4'd12;

  logic [KEY_BITS-1:0] key_mem [CAPACITY];
  logic [ID_BITS-1:0]  id_mem  [CAPACITY];
  logic [PW-1:0]       pos_mem [ID_SPACE];
  logic [ID_SPACE-1:0] present_r;
  logic [CW-1:0]       count_r;

  logic [3:0]          st_r;
  cmd_t                cmd_r;
  logic [1:0]          status_r;
  logic [KEY_BITS-1:0] ckey_r, old_r, k1_r, k2_r;
  logic [ID_BITS-1:0]  cid_r;
  logic [ID_BITS-1:0]  i1_r;
  logic [PW-1:0]       x_r, pos_r, c1_r;
  logic                moved_r, isadj_r, c2ok_r;

  // one registered read port each; key_mem has a second, side read port below
  logic [PW-1:0]       ra;
  logic [KEY_BITS-1:0] rk_r;
  logic [ID_BITS-1:0]  ri_r;
  logic [PW-1:0]       rp_r;
  logic                we;
  logic [PW-1:0]       wa;
  logic [KEY_BITS-1:0] wk;
  logic [ID_BITS-1:0]  wi;
  logic [KEY_BITS-1:0] in_key;
  logic [CW:0]         c1w, c2w;
  logic                take2;
  logic [KEY_BITS-1:0] kmin;

  assign in_key = KEY_BITS'(q_cmd.key);
  assign c1w = {CW'(x_r), 1'b1};
  assign c2w = c1w + (CW+1)'(1);
  // pick the second child only when strictly smaller
  assign take2 = c2ok_r && (k2_r < k1_r);
  assign kmin  = take2 ? k2_r : k1_r;

  always_ff @(posedge clk) begin
    rk_r <= key_mem[ra];
    ri_r <= id_mem[ra];
    rp_r <= pos_mem[q_cmd.id];
    if (we) begin
      key_mem[wa] <= wk;
      id_mem[wa]  <= wi;
      pos_mem[wi] <= wa;
    end
  end

  always_comb begin
    ra = '0;
    we = 1'b0;
    wa = x_r;
    wk = ckey_r;
    wi = cid_r;
    case (st_r)
      S_RPOS:  ra = pos_r;
      S_RLAST: ra = PW'(count_r);
      S_UPRD:  ra = PW'((x_r - 1'b1) >> 1);
      S_DNRD:  ra = PW'(c1w);
      S_DNRD2: ra = PW'(c2w);
      S_UPCMP: if (x_r != '0 && ckey_r < rk_r) begin
        we = 1'b1; wk = rk_r; wi = ri_r;
      end
      S_DNCMP: if (c1w < (CW+1)'(count_r) && ckey_r > kmin) begin
        we = 1'b1;
        wk = kmin;
        wi = take2 ? ri_r : i1_r;
      end
      S_DONE:  we = 1'b1;
      default: ;
    endcase
  end

  assign q_pop = (st_r == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      st_r <= S_IDLE;
      present_r <= '0;
      count_r <= '0;
    end else begin
      out_valid <= (st_r == S_OUT);
      case (st_r)
        S_IDLE: if (q_valid) begin
          cmd_r <= q_cmd; status_r <= ST_OK; cid_r <= q_cmd.id;
          ckey_r <= in_key; moved_r <= 1'b0;
          isadj_r <= (q_cmd.req == REQ_ADJUST);
          st_r <= S_TOP;
          if (q_cmd.req == REQ_INSERT) begin
            if (present_r[q_cmd.id]) status_r <= ST_PRESENT;
            else if (count_r >= CW'(CAPACITY)) status_r <= ST_FULL;
            else begin
              present_r[q_cmd.id] <= 1'b1;
              x_r <= PW'(count_r);
              count_r <= count_r + 1'b1;
              st_r <= S_UPRD;
            end
          end else if (q_cmd.req == REQ_ADJUST || q_cmd.req == REQ_REMOVE) begin
            if (!present_r[q_cmd.id]) status_r <= ST_ABSENT;
            else st_r <= S_WAIT;
          end
        end
        S_WAIT: begin pos_r <= rp_r; x_r <= rp_r; st_r <= S_RPOS; end
        S_RPOS: begin
          // slot at pos is read here; for a remove the last slot is read next
          st_r <= S_RLAST;
          if (cmd_r.req == REQ_REMOVE) begin
            count_r <= count_r - 1'b1;
            present_r[cmd_r.id] <= 1'b0;
          end else st_r <= S_UPRD;
        end
        S_RLAST: begin
          old_r <= rk_r;
          st_r <= S_SEL;
        end
        S_SEL: begin
          if (pos_r == PW'(count_r)) st_r <= S_TOP;
          else begin
            ckey_r <= rk_r; cid_r <= ri_r;
            if (rk_r < old_r) st_r <= S_UPRD;
            else if (rk_r > old_r) st_r <= S_DNRD;
            else st_r <= S_DONE;
          end
        end
        S_UPRD: st_r <= S_UPCMP;
        S_UPCMP: begin
          if (x_r != '0 && ckey_r < rk_r) begin
            x_r <= PW'((x_r - 1'b1) >> 1); moved_r <= 1'b1; st_r <= S_UPRD;
          end else if (isadj_r && !moved_r) st_r <= S_DNRD;
          else st_r <= S_DONE;
        end
        S_DNRD: st_r <= S_DNRD2;
        S_DNRD2: begin
          k1_r <= rk_r; i1_r <= ri_r; c1_r <= PW'(c1w);
          c2ok_r <= c2w < (CW+1)'(count_r);
          st_r <= S_DNCMP;
        end
        S_DNCMP: begin
          if (c1w < (CW+1)'(count_r) && ckey_r > kmin) begin
            x_r <= take2 ? PW'(c2w) : c1_r; st_r <= S_DNRD;
          end else st_r <= S_DONE;
        end
        S_DONE: st_r <= S_TOP;
        S_TOP: st_r <= S_OUT;
        S_OUT: begin
          out_status <= status_r;
          out_top_valid <= (count_r != '0);
          out_top_id <= (count_r != '0) ? ri_r : '0;
          out_top_key <= (count_r != '0) ? 32'(rk_r) : '0;
          out_entry_count <= 9'(count_r);
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // second child's key comes in on a side read port
  always_ff @(posedge clk) if (st_r == S_DNRD2) k2_r <= key_mem[PW'(c2w)];
endmodule
